// ===== rtl/ihlp_pkg.sv =====
// Package for the ID hash index with linear probing.
// Holds the transfer structs, command and status codes, the FSM state type and
// the hash constant. No dependencies.
package ihlp_pkg;

  // Commands carried in an input transfer.
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [2:0] STATUS_FOUND    = 3'd0;
  localparam logic [2:0] STATUS_INSERTED = 3'd1;
  localparam logic [2:0] STATUS_MISS     = 3'd2;
  localparam logic [2:0] STATUS_FULL     = 3'd3;
  localparam logic [2:0] STATUS_CLEARED  = 3'd4;

  // Fibonacci hashing multiplier and the reset value of the capacity register.
  localparam logic [31:0] HASH_MULT      = 32'd2654435761;
  localparam logic [8:0]  CAPACITY_RESET = 9'd256;

  // One input transfer.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] obj_id;
  } item_t;

  // One result transfer.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot_index;
    logic [8:0] entry_count;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SWEEP,
    FSM_HOME,
    FSM_BUCKET,
    FSM_COMPARE
  } state_t;

endpackage

// ===== rtl/id_hash_index_linear_probe_core.sv =====
// Top level of the ID hash index: a bucket memory and a slot memory walked by
// a probe controller that reads, compares and writes back.
// Depends on ihlp_pkg.
//
//  Channel  | Ports                  | Transfer condition
//  ---------+------------------------+------------------------------
//  input    | start, busy, item      | start high while busy is low
//  result   | done, result           | done high for one cycle
//  config   | cfg_we, cfg_wdata      | cfg_we high
//
// After reset the bucket memory is swept to empty, one bucket a cycle, with
// busy held high; a clear command runs the same sweep and then reports.
// A lookup or insert reads the home bucket and walks on from it: each occupied
// bucket needs a bucket read then a slot read, and the walk ends on a match,
// on an empty bucket or at the end of the chain.
// The result is registered and leaves the block in the cycle busy falls; the
// receiver cannot stall it.
module id_hash_index_linear_probe_core #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned BUCKETS     = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ihlp_pkg::item_t   item,
  output logic              done,
  output ihlp_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata
);

  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int VAL_W  = $clog2(MAX_ENTRIES + 1);
  localparam int BKT_W  = $clog2(BUCKETS);

  // Storage: bucket index holds slot plus one, zero when empty.
  logic [VAL_W-1:0] bkt_mem [BUCKETS];
  logic [15:0]      slot_mem [MAX_ENTRIES];

  logic [VAL_W-1:0]  bkt_rdata;
  logic [BKT_W-1:0]  bkt_raddr;
  logic              bkt_we;
  logic [BKT_W-1:0]  bkt_waddr;
  logic [VAL_W-1:0]  bkt_wdata;
  logic [15:0]       slot_rdata;
  logic [SLOT_W-1:0] slot_raddr;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;

  // Registers and their next values.
  ihlp_pkg::state_t  state, state_next;
  logic [1:0]        op, op_next;
  logic [15:0]       key, key_next;
  logic [31:0]       hash, hash_next;
  logic [BKT_W-1:0]  cur_bkt, cur_bkt_next;
  logic [BKT_W-1:0]  probe_cnt, probe_cnt_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;
  logic [VAL_W-1:0]  count, count_next;
  logic [BKT_W-1:0]  sweep_addr, sweep_addr_next;
  logic              sweep_report, sweep_report_next;
  logic              done_next;
  ihlp_pkg::result_t result_next;
  logic [8:0]        capacity;

  // Derived values.
  logic [BKT_W-1:0] home_top;
  logic [BKT_W-1:0] home;
  logic [BKT_W-1:0] next_bkt;
  logic [VAL_W-1:0] val_m1;
  logic             val_in_range;
  logic             at_cap;
  logic             chain_end;

  // Packs a result, truncating slot and count to their field widths.
  function automatic ihlp_pkg::result_t make_result(logic [2:0] st, logic [31:0] slot,
                                                    logic [31:0] cnt);
    ihlp_pkg::result_t r;
    r.status      = st;
    r.slot_index  = slot[7:0];
    r.entry_count = cnt[8:0];
    return r;
  endfunction

  // Bucket memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata <= bkt_mem[bkt_raddr];
  end

  // Slot memory: holds the IDs in first-use order.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= key;
    end
    slot_rdata <= slot_mem[slot_raddr];
  end

  // Capacity register, written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ihlp_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Home bucket from the top bits of the hash, folded once if beyond the range.
  assign home_top = hash[31 -: BKT_W];
  assign home = ({1'b0, home_top} >= (BKT_W + 1)'(BUCKETS))
              ? BKT_W'({1'b0, home_top} - (BKT_W + 1)'(BUCKETS)) : home_top;
  assign next_bkt  = (cur_bkt == BKT_W'(BUCKETS - 1)) ? '0 : cur_bkt + 1'b1;
  assign val_m1    = bkt_rdata - 1'b1;
  assign val_in_range = (32'(val_m1) < MAX_ENTRIES);
  assign at_cap    = (32'(count) >= 32'(capacity)) || (32'(count) >= MAX_ENTRIES);
  assign chain_end = (probe_cnt == BKT_W'(BUCKETS - 1));

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ihlp_pkg::FSM_SWEEP;
      count        <= '0;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      sweep_addr   <= sweep_addr_next;
      sweep_report <= sweep_report_next;
      done         <= done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op        <= op_next;
    key       <= key_next;
    hash      <= hash_next;
    cur_bkt   <= cur_bkt_next;
    probe_cnt <= probe_cnt_next;
    cur_slot  <= cur_slot_next;
    result    <= result_next;
  end

  assign busy = (state != ihlp_pkg::FSM_IDLE);

  // Probe controller: next state, memory accesses and result.
  always_comb begin
    state_next        = state;
    op_next           = op;
    key_next          = key;
    hash_next         = hash;
    cur_bkt_next      = cur_bkt;
    probe_cnt_next    = probe_cnt;
    cur_slot_next     = cur_slot;
    count_next        = count;
    sweep_addr_next   = sweep_addr;
    sweep_report_next = sweep_report;
    done_next         = 1'b0;
    result_next       = result;
    bkt_raddr         = cur_bkt;
    bkt_we            = 1'b0;
    bkt_waddr         = cur_bkt;
    bkt_wdata         = '0;
    slot_raddr        = cur_slot;
    slot_we           = 1'b0;
    slot_waddr        = count[SLOT_W-1:0];

    case (state)
      ihlp_pkg::FSM_IDLE: begin
        if (start) begin
          op_next   = item.command;
          key_next  = item.obj_id;
          hash_next = {16'd0, item.obj_id} * ihlp_pkg::HASH_MULT;
          if (item.command == ihlp_pkg::CMD_CLEAR) begin
            count_next        = '0;
            sweep_addr_next   = '0;
            sweep_report_next = 1'b1;
            state_next        = ihlp_pkg::FSM_SWEEP;
          end else begin
            state_next = ihlp_pkg::FSM_HOME;
          end
        end
      end

      // Empty every bucket, one per cycle.
      ihlp_pkg::FSM_SWEEP: begin
        bkt_we    = 1'b1;
        bkt_waddr = sweep_addr;
        if (sweep_addr == BKT_W'(BUCKETS - 1)) begin
          sweep_addr_next = '0;
          state_next      = ihlp_pkg::FSM_IDLE;
          if (sweep_report) begin
            done_next   = 1'b1;
            result_next = make_result(ihlp_pkg::STATUS_CLEARED, 32'd0, 32'd0);
          end
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end

      // Issue the read of the home bucket.
      ihlp_pkg::FSM_HOME: begin
        bkt_raddr      = home;
        cur_bkt_next   = home;
        probe_cnt_next = '0;
        state_next     = ihlp_pkg::FSM_BUCKET;
      end

      // Bucket data is back: stop on empty, fetch the slot's ID if in range, else step on or end at the chain's end.
      ihlp_pkg::FSM_BUCKET: begin
        if (bkt_rdata == '0) begin
          done_next  = 1'b1;
          state_next = ihlp_pkg::FSM_IDLE;
          if (op == ihlp_pkg::CMD_INSERT) begin
            if (at_cap) begin
              result_next = make_result(ihlp_pkg::STATUS_FULL, 32'd0, 32'(count));
            end else begin
              bkt_we      = 1'b1;
              bkt_wdata   = count + 1'b1;
              slot_we     = 1'b1;
              count_next  = count + 1'b1;
              result_next = make_result(ihlp_pkg::STATUS_INSERTED, 32'(count),
                                        32'(count) + 32'd1);
            end
          end else begin
            result_next = make_result(ihlp_pkg::STATUS_MISS, 32'd0, 32'(count));
          end
        end else if (val_in_range) begin
          slot_raddr    = val_m1[SLOT_W-1:0];
          cur_slot_next = val_m1[SLOT_W-1:0];
          state_next    = ihlp_pkg::FSM_COMPARE;
        end else if (chain_end) begin
          done_next   = 1'b1;
          state_next  = ihlp_pkg::FSM_IDLE;
          result_next = make_result((op == ihlp_pkg::CMD_INSERT) ? ihlp_pkg::STATUS_FULL
                                    : ihlp_pkg::STATUS_MISS, 32'd0, 32'(count));
        end else begin
          bkt_raddr      = next_bkt;
          cur_bkt_next   = next_bkt;
          probe_cnt_next = probe_cnt + 1'b1;
        end
      end

      // Slot ID is back: a match ends the walk, else step to the next bucket or end at the chain's end.
      ihlp_pkg::FSM_COMPARE: begin
        if (slot_rdata == key) begin
          done_next   = 1'b1;
          state_next  = ihlp_pkg::FSM_IDLE;
          result_next = make_result(ihlp_pkg::STATUS_FOUND, 32'(cur_slot), 32'(count));
        end else if (chain_end) begin
          done_next   = 1'b1;
          state_next  = ihlp_pkg::FSM_IDLE;
          result_next = make_result((op == ihlp_pkg::CMD_INSERT) ? ihlp_pkg::STATUS_FULL
                                    : ihlp_pkg::STATUS_MISS, 32'd0, 32'(count));
        end else begin
          bkt_raddr      = next_bkt;
          cur_bkt_next   = next_bkt;
          probe_cnt_next = probe_cnt + 1'b1;
          state_next     = ihlp_pkg::FSM_BUCKET;
        end
      end

      default: begin
        state_next = ihlp_pkg::FSM_IDLE;
      end
    endcase
  end

  // The stored count never passes the table size.
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= MAX_ENTRIES)
    else $error("stored count exceeds table size");

  // An inserted result comes with the count raised by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ihlp_pkg::STATUS_INSERTED) |->
      (count == $past(count) + 1'b1))
    else $error("insert did not advance the count by one");

  // A result is only presented once the controller has returned to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // No bucket is written while the controller is idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ihlp_pkg::FSM_IDLE) |-> !bkt_we)
    else $error("bucket write while idle");

endmodule

// ===== tb/tb_id_hash_index_linear_probe_core.sv =====
// Self-checking testbench for id_hash_index_linear_probe_core: directed and random
// lookup, insert, clear and capacity traffic checked against a behavioural index.
// Depends on ihlp_pkg and the core RTL only.
module tb_id_hash_index_linear_probe_core;

  // Command three carries no operation and must behave as a lookup.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TABLE_SLOTS = 256;
  localparam int BUCKET_COUNT = 512;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  // Behavioural copy of the index, plus the queue of replies still owed.
  class id_index_tracker;
    logic [15:0] slot_ids [TABLE_SLOTS];
    int unsigned bucket_slot [BUCKET_COUNT];
    int unsigned stored;
    logic [8:0] capacity;
    ihlp_pkg::result_t pending_replies [$];
    int failures;

    function new();
      foreach (bucket_slot[i]) bucket_slot[i] = 0;
      stored = 0;
      capacity = ihlp_pkg::CAPACITY_RESET;
      failures = 0;
    endfunction

    // Home bucket: top nine bits of the 32-bit Fibonacci product.
    static function logic [8:0] home_of(logic [15:0] id);
      logic [31:0] product;
      product = {16'd0, id} * ihlp_pkg::HASH_MULT;
      return product[31:23];
    endfunction

    // Works out the reply to an accepted input transfer and updates the index.
    function void note_item(ihlp_pkg::item_t it);
      ihlp_pkg::result_t r;
      int unsigned b;
      int unsigned empty_b;
      int unsigned v;
      int unsigned cap;
      int n;
      bit hit;
      bit has_empty;
      r.status = ihlp_pkg::STATUS_MISS;
      r.slot_index = '0;
      if (it.command == ihlp_pkg::CMD_CLEAR) begin
        foreach (bucket_slot[i]) bucket_slot[i] = 0;
        stored = 0;
        r.status = ihlp_pkg::STATUS_CLEARED;
      end else begin
        b = home_of(it.obj_id);
        hit = 0;
        has_empty = 0;
        empty_b = 0;
        for (n = 0; n < BUCKET_COUNT && !hit && !has_empty; n++) begin
          v = bucket_slot[b];
          if (v == 0) begin
            has_empty = 1;
            empty_b = b;
          end else if (slot_ids[v - 1] == it.obj_id) begin
            hit = 1;
            r.status = ihlp_pkg::STATUS_FOUND;
            r.slot_index = 8'(v - 1);
          end else begin
            b = (b + 1) % BUCKET_COUNT;
          end
        end
        // Only a genuine insert may append; command three never does.
        if (!hit && it.command == ihlp_pkg::CMD_INSERT) begin
          cap = (capacity > TABLE_SLOTS) ? TABLE_SLOTS : capacity;
          if (stored >= cap || !has_empty) begin
            r.status = ihlp_pkg::STATUS_FULL;
          end else begin
            slot_ids[stored] = it.obj_id;
            bucket_slot[empty_b] = stored + 1;
            r.slot_index = 8'(stored);
            r.status = ihlp_pkg::STATUS_INSERTED;
            stored++;
          end
        end
      end
      r.entry_count = 9'(stored);
      pending_replies.push_back(r);
    endfunction

    // Compares one result transfer with the oldest reply owed.
    function void check_result(ihlp_pkg::result_t got);
      ihlp_pkg::result_t want;
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: status %0d slot %0d count %0d",
                   got.status, got.slot_index, got.entry_count);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.entry_count !== want.entry_count) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display({"mismatch: expected status %0d slot %0d count %0d, ",
                    "got status %0d slot %0d count %0d"},
                   want.status, want.slot_index, want.entry_count,
                   got.status, got.slot_index, got.entry_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  ihlp_pkg::item_t item;
  logic done;
  ihlp_pkg::result_t result;
  logic cfg_we;
  logic [8:0] cfg_wdata;

  id_index_tracker tracker = new;
  logic [15:0] known_ids [$];
  int burst_left;
  int idle_cycles;

  id_hash_index_linear_probe_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every result transfer is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_result(result);
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_id_hash_index_linear_probe_core failed");
      $finish;
    end
  end

  // Sender gaps: mostly none or short, a few long, with bursts of back-to-back items.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one item and returns at the edge where the transfer is taken.
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] id);
    int gap;
    ihlp_pkg::item_t it;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.command = cmd;
    it.obj_id = id;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_item(it);
  endtask

  // Holds the sender off until every reply owed has arrived and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending_replies.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    tracker.capacity = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic; known IDs are reused so that lookups and repeat inserts hit.
  task automatic run_phase(input int items, input int insert_pct, input int clear_pct);
    int r;
    int reuse_pct;
    logic [1:0] cmd;
    logic [15:0] id;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct) cmd = ihlp_pkg::CMD_CLEAR;
      else if (r < clear_pct + 3) cmd = CMD_UNUSED;
      else if (r < clear_pct + 3 + insert_pct) cmd = ihlp_pkg::CMD_INSERT;
      else cmd = ihlp_pkg::CMD_LOOKUP;
      reuse_pct = (cmd == ihlp_pkg::CMD_INSERT) ? 20 : 60;
      if (known_ids.size() != 0 && $urandom_range(0, 99) < reuse_pct)
        id = known_ids[$urandom_range(0, known_ids.size() - 1)];
      else
        id = 16'($urandom);
      if (cmd == ihlp_pkg::CMD_INSERT) known_ids.push_back(id);
      if (cmd == ihlp_pkg::CMD_CLEAR) known_ids.delete();
      if ($urandom_range(0, 99) < 2) drain();
      send_item(cmd, id);
    end
  endtask

  initial begin
    logic [15:0] wrap_ids [$];
    logic [15:0] probe_id;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Four IDs that all hash to the last bucket, so their chain wraps to bucket 0.
    probe_id = 16'($urandom);
    while (wrap_ids.size() < 4) begin
      if (id_index_tracker::home_of(probe_id) == 9'd511) wrap_ids.push_back(probe_id);
      probe_id = probe_id + 16'd1;
    end

    // Directed part: extreme IDs, every command, repeats and a wrapping chain.
    write_capacity(9'd256);
    send_item(ihlp_pkg::CMD_LOOKUP, 16'h0000);
    send_item(ihlp_pkg::CMD_INSERT, 16'h0000);
    send_item(ihlp_pkg::CMD_INSERT, 16'hFFFF);
    send_item(ihlp_pkg::CMD_INSERT, 16'h0000);
    send_item(ihlp_pkg::CMD_LOOKUP, 16'hFFFF);
    send_item(ihlp_pkg::CMD_LOOKUP, 16'h1234);
    send_item(CMD_UNUSED, 16'hFFFF);
    send_item(CMD_UNUSED, 16'hABCD);
    send_item(ihlp_pkg::CMD_LOOKUP, 16'hABCD);
    send_item(ihlp_pkg::CMD_INSERT, wrap_ids[0]);
    send_item(ihlp_pkg::CMD_INSERT, wrap_ids[1]);
    send_item(ihlp_pkg::CMD_INSERT, wrap_ids[2]);
    send_item(ihlp_pkg::CMD_LOOKUP, wrap_ids[2]);
    send_item(ihlp_pkg::CMD_LOOKUP, wrap_ids[3]);

    // A zero capacity refuses every new ID but still finds stored ones.
    write_capacity(9'd0);
    send_item(ihlp_pkg::CMD_INSERT, 16'h5555);
    send_item(ihlp_pkg::CMD_INSERT, 16'h0000);

    // Capacity lowered below the count of stored IDs.
    write_capacity(9'd3);
    send_item(ihlp_pkg::CMD_INSERT, 16'h5555);
    send_item(ihlp_pkg::CMD_LOOKUP, wrap_ids[1]);
    send_item(ihlp_pkg::CMD_CLEAR, 16'h0000);
    send_item(ihlp_pkg::CMD_LOOKUP, 16'h0000);

    write_capacity(9'd1);
    send_item(ihlp_pkg::CMD_INSERT, 16'h7777);
    send_item(ihlp_pkg::CMD_INSERT, 16'h8888);
    send_item(ihlp_pkg::CMD_CLEAR, 16'hFFFF);
    known_ids.delete();

    // Random part: fill the table, saturate the capacity, then churn with clears.
    write_capacity(9'd256);
    run_phase(220, 75, 0);
    write_capacity(9'd511);
    run_phase(160, 90, 0);
    write_capacity(9'd1);
    run_phase(30, 50, 0);
    write_capacity(9'd40);
    run_phase(100, 60, 4);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_replies.size() == 0)
      $display("tb_id_hash_index_linear_probe_core passed");
    else
      $display("tb_id_hash_index_linear_probe_core failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ihlp_pkg.sv
rtl/id_hash_index_linear_probe_core.sv
tb/tb_id_hash_index_linear_probe_core.sv
